/* design/q2e_pkg.sv */
// Shared types and constants for the quaternion to Euler angle converter.
// Depends on nothing; every other design file but q2e_checker imports it.
`default_nettype none
package q2e_pkg;

	localparam int QW    = 16;  // quaternion component, Q2.14
	localparam int PW    = 32;  // product of two components, Q.28
	localparam int NW    = 34;  // atan2 numerator and raw asin argument
	localparam int DW    = 35;  // atan2 denominator
	localparam int SW    = 30;  // saturated asin argument
	localparam int SMAGW = 29;  // magnitude of the asin argument
	localparam int RADW  = 57;  // radicand 1 - s^2 in Q.56
	localparam int ROOTW = 29;  // square root of the radicand
	localparam int RW    = 59;  // square root working width
	localparam int CW    = 38;  // CORDIC x and y width
	localparam int ZW    = 27;  // CORDIC angle accumulator, 2^-16 degree
	localparam int AXW   = 15;
	localparam int AYW   = 16;

	localparam int SQRT_STEPS = 29;
	localparam int QDEPTH     = 4;
	localparam int QPTRW      = 2;
	localparam int QCNTW      = 3;

	localparam logic signed [DW-1:0] ONE_Q28  = DW'(64'sd268435456);
	localparam logic [RADW-1:0]      ONE_Q56  = RADW'(1) << 56;
	localparam logic signed [ZW-1:0] DEG180   = ZW'(32'sd11796480);
	localparam logic signed [ZW-1:0] LIM_X    = ZW'(32'sd11520);
	localparam logic signed [ZW-1:0] LIM_YZ   = ZW'(32'sd23040);

	// atan(2^-i) in units of 2^-16 degree
	localparam logic signed [ZW-1:0] ATAN_TAB [0:23] = '{
		ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
		ZW'(234379), ZW'(117304), ZW'(58666), ZW'(29335),
		ZW'(14668), ZW'(7334), ZW'(3667), ZW'(1833),
		ZW'(917), ZW'(458), ZW'(229), ZW'(115),
		ZW'(57), ZW'(29), ZW'(14), ZW'(7),
		ZW'(4), ZW'(2), ZW'(1), ZW'(0)
	};

	// One prepared item, handed from the front end to the back end.
	typedef struct packed {
		logic signed [NW-1:0] ny;
		logic signed [DW-1:0] dy;
		logic signed [NW-1:0] nz;
		logic signed [DW-1:0] dz;
		logic signed [SW-1:0] s;
		logic [RADW-1:0]      rad;
		logic                 clamped;
	} q2e_item_t;

endpackage
`default_nettype wire

/* design/q2e_front.sv */
// Front end: forms the quaternion products, the atan2 operands, the saturated
// asin argument and the radicand 1 - s^2. Uses q2e_pkg.
`default_nettype none
module q2e_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [15:0]        quat_w,
	input  wire logic signed [15:0]        quat_x,
	input  wire logic signed [15:0]        quat_y,
	input  wire logic signed [15:0]        quat_z,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output q2e_pkg::q2e_item_t             out_item
);
	import q2e_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [PW-1:0] ab_s1, cd_s1, bb_s1, cc_s1, ad_s1, bc_s1, dd_s1, ac_s1, db_s1;
	logic signed [NW-1:0] ny_s2, nz_s2, ny_s3, nz_s3;
	logic signed [DW-1:0] dy_s2, dz_s2, dy_s3, dz_s3;
	logic signed [SW-1:0] s_s2, s_s3;
	logic                 cl_s2, cl_s3;
	logic [RADW-1:0]      sq_s3;
	logic signed [NW-1:0] s_raw;
	logic signed [SW-1:0] s_abs;

	// Naming follows the convention a = w, b = y, c = x, d = z.
	assign en       = !v_s3 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s1 <= PW'(quat_w) * PW'(quat_y);
			cd_s1 <= PW'(quat_x) * PW'(quat_z);
			bb_s1 <= PW'(quat_y) * PW'(quat_y);
			cc_s1 <= PW'(quat_x) * PW'(quat_x);
			ad_s1 <= PW'(quat_w) * PW'(quat_z);
			bc_s1 <= PW'(quat_y) * PW'(quat_x);
			dd_s1 <= PW'(quat_z) * PW'(quat_z);
			ac_s1 <= PW'(quat_w) * PW'(quat_x);
			db_s1 <= PW'(quat_z) * PW'(quat_y);
		end
	end

	assign s_raw = (NW'(ac_s1) - NW'(db_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			ny_s2 <= (NW'(ab_s1) + NW'(cd_s1)) <<< 1;
			nz_s2 <= (NW'(ad_s1) + NW'(bc_s1)) <<< 1;
			dy_s2 <= ONE_Q28 - ((DW'(bb_s1) + DW'(cc_s1)) <<< 1);
			dz_s2 <= ONE_Q28 - ((DW'(cc_s1) + DW'(dd_s1)) <<< 1);
			if (s_raw > NW'(ONE_Q28)) begin
				s_s2  <= SW'(ONE_Q28);
				cl_s2 <= 1'b1;
			end else if (s_raw < -NW'(ONE_Q28)) begin
				s_s2  <= -SW'(ONE_Q28);
				cl_s2 <= 1'b1;
			end else begin
				s_s2  <= SW'(s_raw);
				cl_s2 <= 1'b0;
			end
		end
	end

	assign s_abs = s_s2[SW-1] ? -s_s2 : s_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ny_s3 <= ny_s2;
			nz_s3 <= nz_s2;
			dy_s3 <= dy_s2;
			dz_s3 <= dz_s2;
			s_s3  <= s_s2;
			cl_s3 <= cl_s2;
			sq_s3 <= RADW'(s_abs[SMAGW-1:0]) * RADW'(s_abs[SMAGW-1:0]);
		end
	end

	assign out_valid        = v_s3;
	assign out_item.ny      = ny_s3;
	assign out_item.dy      = dy_s3;
	assign out_item.nz      = nz_s3;
	assign out_item.dz      = dz_s3;
	assign out_item.s       = s_s3;
	assign out_item.rad     = ONE_Q56 - sq_s3;
	assign out_item.clamped = cl_s3;

endmodule
`default_nettype wire

/* design/q2e_queue.sv */
// Short queue of prepared items between the front end and the back end.
// Uses q2e_pkg for the item type and depth.
`default_nettype none
module q2e_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  q2e_pkg::q2e_item_t in_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output q2e_pkg::q2e_item_t out_item
);
	import q2e_pkg::*;

	q2e_item_t        mem_q [0:QDEPTH-1];
	logic [QPTRW-1:0] wr_q, rd_q;
	logic [QCNTW-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != QCNTW'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + QCNTW'(push) - QCNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

endmodule
`default_nettype wire

/* design/q2e_isqrt.sv */
// Pipelined restoring integer square root, one result bit per stage.
// Uses q2e_pkg for widths and the stage count.
`default_nettype none
module q2e_isqrt (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [56:0]        rad,
	output logic [28:0]             root
);
	import q2e_pkg::*;

	logic [RW-1:0] rem_s [0:SQRT_STEPS-1];
	logic [RW-1:0] res_s [0:SQRT_STEPS-1];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
		localparam int SH = 2 * (SQRT_STEPS - 1 - k);
		localparam logic [RW-1:0] BITV = RW'(1) << SH;
		logic [RW-1:0] rem_in, res_in, trial;

		if (k == 0) begin : g_first
			assign rem_in = RW'(rad);
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
		end

		assign trial = res_in + BITV;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BITV;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[SQRT_STEPS-1][ROOTW-1:0];

endmodule
`default_nettype wire

/* design/q2e_cordic.sv */
// Pipelined vectoring CORDIC: one quadrant fold stage, then one micro-rotation
// per stage. Gives atan2 in 2^-16 degree. Uses q2e_pkg.
`default_nettype none
module q2e_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [37:0] y_in,
	input  wire logic signed [37:0] x_in,
	output logic signed [26:0]      z_out,
	output logic                    zero_out
);
	import q2e_pkg::*;

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];

	// Fold the left half plane onto the right; on the negative x axis the
	// angle comes out as +180 degrees.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? DEG180 : -DEG180;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_rot
		logic signed [CW-1:0] xs, ys;
		assign xs = x_s[k-1] >>> (k - 1);
		assign ys = y_s[k-1] >>> (k - 1);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k] <= zero_s[k-1];
				if (y_s[k-1] < 0) begin
					x_s[k] <= x_s[k-1] - ys;
					y_s[k] <= y_s[k-1] + xs;
					z_s[k] <= z_s[k-1] - ATAN_TAB[k-1];
				end else begin
					x_s[k] <= x_s[k-1] + ys;
					y_s[k] <= y_s[k-1] - xs;
					z_s[k] <= z_s[k-1] + ATAN_TAB[k-1];
				end
			end
		end
	end

	assign z_out    = z_s[STEPS];
	assign zero_out = zero_s[STEPS];

endmodule
`default_nettype wire

/* design/q2e_back.sv */
// Back end: square root for the asin term, three CORDIC lanes, rounding to
// 1/128 degree and the output register. Uses q2e_pkg, q2e_isqrt, q2e_cordic.
`default_nettype none
module q2e_back #(
	parameter int STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  q2e_pkg::q2e_item_t      in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [14:0]      angle_x,
	output logic signed [15:0]      angle_y,
	output logic signed [15:0]      angle_z,
	output logic                    asin_clamped
);
	import q2e_pkg::*;

	logic                 en;
	q2e_item_t            side_s [0:SQRT_STEPS-1];
	logic                 sv_s   [0:SQRT_STEPS-1];
	logic                 cv_s   [0:STEPS];
	logic                 cc_s   [0:STEPS];
	logic [ROOTW-1:0]     root;
	logic signed [ZW-1:0] zx, zy, zz;
	logic                 zerox, zeroy, zeroz;
	logic                 valid_q;
	logic signed [AXW-1:0] ax_q;
	logic signed [AYW-1:0] ay_q, az_q;
	logic                 cl_q;

	function automatic logic signed [AYW-1:0] round_sat(
		input logic signed [ZW-1:0] z,
		input logic signed [ZW-1:0] lim
	);
		logic signed [ZW-1:0] r;
		r = (z + ZW'(256)) >>> 9;
		if (r > lim) r = lim;
		else if (r < -lim) r = -lim;
		return AYW'(r);
	endfunction

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (in_item.rad),
		.root (root)
	);

	// Side data rides alongside the square root stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_STEPS; k++) sv_s[k] <= 1'b0;
			for (int k = 0; k <= STEPS; k++) cv_s[k] <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			sv_s[0] <= in_valid;
			for (int k = 1; k < SQRT_STEPS; k++) sv_s[k] <= sv_s[k-1];
			cv_s[0] <= sv_s[SQRT_STEPS-1];
			for (int k = 1; k <= STEPS; k++) cv_s[k] <= cv_s[k-1];
			valid_q <= cv_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_item;
			for (int k = 1; k < SQRT_STEPS; k++) side_s[k] <= side_s[k-1];
			cc_s[0] <= side_s[SQRT_STEPS-1].clamped;
			for (int k = 1; k <= STEPS; k++) cc_s[k] <= cc_s[k-1];
		end
	end

	q2e_cordic #(.STEPS(STEPS)) u_lane_x (
		.clk      (clk),
		.en       (en),
		.y_in     (CW'(side_s[SQRT_STEPS-1].s)),
		.x_in     (CW'({1'b0, root})),
		.z_out    (zx),
		.zero_out (zerox)
	);

	q2e_cordic #(.STEPS(STEPS)) u_lane_y (
		.clk      (clk),
		.en       (en),
		.y_in     (CW'(side_s[SQRT_STEPS-1].ny)),
		.x_in     (CW'(side_s[SQRT_STEPS-1].dy)),
		.z_out    (zy),
		.zero_out (zeroy)
	);

	q2e_cordic #(.STEPS(STEPS)) u_lane_z (
		.clk      (clk),
		.en       (en),
		.y_in     (CW'(side_s[SQRT_STEPS-1].nz)),
		.x_in     (CW'(side_s[SQRT_STEPS-1].dz)),
		.z_out    (zz),
		.zero_out (zeroz)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_q <= zerox ? '0 : AXW'(round_sat(zx, LIM_X));
			ay_q <= zeroy ? '0 : round_sat(zy, LIM_YZ);
			az_q <= zeroz ? '0 : round_sat(zz, LIM_YZ);
			cl_q <= cc_s[STEPS];
		end
	end

	assign out_valid    = valid_q;
	assign angle_x      = ax_q;
	assign angle_y      = ay_q;
	assign angle_z      = az_q;
	assign asin_clamped = cl_q;

endmodule
`default_nettype wire

/* design/quaternion_to_euler_angles_top.sv */
// Top level of the quaternion to Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_queue and q2e_back.
//
// Usage:
// One unit quaternion enters per transfer on the s_axis channel; each one
// produces exactly one transfer on the m_axis channel carrying three angles
// in 1/128 degree and a flag that is set when the asin argument saturated.
// Throughput is one item per clock cycle while the receiver does not stall.
// From an input transfer to the output valid, three front stages form the
// products, square and radicand, the item then passes through the queue,
// 29 stages of the pipelined square root follow, then the CORDIC lanes (one
// fold stage plus one stage per micro-rotation) and the output register. The
// square root depth and the CORDIC depth set the delay.
// Reset (arst_n low) empties every pipeline and the queue at once; there is
// no clearing pass and the block is ready as soon as reset is released.
// When the receiver deasserts m_axis_tready the back end holds its contents,
// the four entry queue keeps taking items, and the front end stalls only
// once the queue is full; then s_axis_tready drops.
`default_nettype none
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// angle_x [14:0], angle_y [30:15], angle_z [46:31], zero pad [47]
	output logic [47:0]      m_axis_tdata,
	// asin_clamped [0]
	output logic             m_axis_tuser
);
	import q2e_pkg::*;

	q2e_item_t             front_item, back_item;
	logic                  front_valid, queue_ready;
	logic                  queue_valid, back_ready;
	logic signed [AXW-1:0] angle_x;
	logic signed [AYW-1:0] angle_y, angle_z;

	q2e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.quat_w    (s_axis_tdata[15:0]),
		.quat_x    (s_axis_tdata[31:16]),
		.quat_y    (s_axis_tdata[47:32]),
		.quat_z    (s_axis_tdata[63:48]),
		.out_valid (front_valid),
		.out_ready (queue_ready),
		.out_item  (front_item)
	);

	q2e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (queue_ready),
		.in_item   (front_item),
		.out_valid (queue_valid),
		.out_ready (back_ready),
		.out_item  (back_item)
	);

	q2e_back #(.STEPS(CORDIC_STEPS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (queue_valid),
		.in_ready     (back_ready),
		.in_item      (back_item),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.angle_x      (angle_x),
		.angle_y      (angle_y),
		.angle_z      (angle_z),
		.asin_clamped (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, angle_z, angle_y, angle_x};

endmodule
`default_nettype wire

/* design/q2e_checker.sv */
// Port-level checks for the converter and the bind that attaches them.
// Depends only on the ports of quaternion_to_euler_angles_top.
`default_nettype none
module q2e_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);
	logic [7:0]         pend_q;
	logic signed [14:0] ax;
	logic signed [15:0] ay, az;
	logic               in_xfer, out_xfer;

	assign ax       = m_axis_tdata[14:0];
	assign ay       = m_axis_tdata[30:15];
	assign az       = m_axis_tdata[46:31];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(in_xfer) - 8'(out_xfer);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 8'd0)
		else $error("result without an accepted item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ax >= -15'sd11520 && ax <= 15'sd11520
			&& ay >= -16'sd23040 && ay <= 16'sd23040
			&& az >= -16'sd23040 && az <= 16'sd23040)
		else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_top q2e_checker u_q2e_checker (.*);
`default_nettype wire
